// ----- design/tpmd_pkg.sv -----
// Shared types, codes and constants of the tilt PID motor drive.
package tpmd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DIV_W     = 52;
    localparam int DIVR_W    = 16;
    localparam int DIV_STEPS = 2;
    localparam int DIV_ITER  = DIV_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_MAX  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_MIN  = 3'd6;

    localparam logic        [15:0] RST_GAIN_P        = 16'd256;
    localparam logic        [15:0] RST_SAMPLE_PERIOD = 16'd655;
    localparam logic signed [31:0] RST_INTEGRAL_MAX  = 32'sd40960;
    localparam logic signed [31:0] RST_INTEGRAL_MIN  = -32'sd40960;

    localparam logic signed [16:0] SAT_HI     = 17'sd32767;
    localparam logic signed [16:0] SAT_LO     = -17'sd32768;
    localparam logic signed [15:0] TILT_LIMIT = 16'sd2867;
    localparam logic signed [17:0] DLT_HI     = 18'sd410;
    localparam logic signed [17:0] DLT_LO     = -18'sd410;
    localparam logic        [18:0] DTM_LIMIT  = 19'd491520;
    localparam logic [DIVR_W-1:0]  C_SCALE    = 16'd40960;
    localparam logic        [31:0] MAG_CLIP   = 32'h8000_0000;
    localparam logic signed [15:0] CN_MAX     = 16'sh7FFF;
    localparam logic signed [15:0] CN_MIN     = 16'sh8000;
    localparam logic        [16:0] CN_NEG_MAG = 17'd32768;
    localparam logic        [14:0] THROTTLE_MAX = 15'h7FFF;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        DSEL_AVG = 2'd0,
        DSEL_I   = 2'd1,
        DSEL_D   = 2'd2,
        DSEL_C   = 2'd3
    } div_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RING,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_ERR,
        ST_MUL_SDT,
        ST_MUL_KDDT,
        ST_MUL_NI,
        ST_MUL_ND,
        ST_I_GO,
        ST_I_WAIT,
        ST_D_GO,
        ST_D_WAIT,
        ST_SUM,
        ST_CLIP,
        ST_MUL_CP,
        ST_C_GO,
        ST_C_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     ring_update;
        logic     div_start;
        logic     div_capture;
        div_sel_t div_sel;
        logic     err_update;
        logic     mul_sdt;
        logic     mul_kddt;
        logic     mul_ni;
        logic     mul_nd;
        logic     sum_update;
        logic     clip_update;
        logic     mul_cp;
        logic     result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage

// ----- design/tilt_pid_motor_drive.sv -----
// Top level of the tilt PID motor drive: controller and datapath.
//
//   Channel  | Signals                                            | Beat taken when
//   ---------+----------------------------------------------------+--------------------------
//   input    | tilt_sample                                        | in_valid and in_ready
//   output   | direction, throttle, control_value, tilt_exceeded  | out_valid and out_ready
//   config   | cfg_index, cfg_data                                | cfg_write
//
// One input beat is processed at a time; from acceptance until the result is loaded it makes
// four passes through the shared divider.
// The next beat is taken while a finished result still waits in the output register.
// A finished result is held back only while the previous one has not been taken.
// Reset clears the averaging ring through per-entry valid bits, so no clearing pass runs.
module tilt_pid_motor_drive
    import tpmd_pkg::*;
#(
    parameter int RING_LENGTH = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [15:0]    tilt_sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            direction,
    output logic [14:0]           throttle,
    output logic signed [15:0]    control_value,
    output logic                  tilt_exceeded
);

    dp_cmd_t    cmd;
    dp_status_t status;

    tpmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    tpmd_datapath #(
        .RING_LENGTH (RING_LENGTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .tilt_sample   (tilt_sample),
        .cmd           (cmd),
        .status        (status),
        .direction     (direction),
        .throttle      (throttle),
        .control_value (control_value),
        .tilt_exceeded (tilt_exceeded)
    );

endmodule

// ----- design/tpmd_divider.sv -----
// Iterative unsigned restoring divider, two quotient bits per cycle.
module tpmd_divider
    import tpmd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic [DIV_W-1:0]  quotient,
    output logic              done
);

    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     quo_next;
    logic [DIVR_W-1:0]    rem_reg;
    logic [DIVR_W-1:0]    rem_next;
    logic [DIVR_W-1:0]    dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    always_comb
    begin
        logic [DIVR_W:0]   trial;
        logic [DIVR_W-1:0] rem_v;
        logic [DIV_W-1:0]  quo_v;
        rem_v = rem_reg;
        quo_v = quo_reg;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial = {rem_v, quo_v[DIV_W-1]};
            quo_v = {quo_v[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_v    = DIVR_W'(trial - {1'b0, dsr_reg});
                quo_v[0] = 1'b1;
            end
            else
            begin
                rem_v = trial[DIVR_W-1:0];
            end
        end
        rem_next = rem_v;
        quo_next = quo_v;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_ITER);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- design/tpmd_datapath.sv -----
// Datapath: configuration registers, averaging ring, PID arithmetic and result register.
module tpmd_datapath
    import tpmd_pkg::*;
#(
    parameter int RING_LENGTH = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic signed [15:0]      tilt_sample,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    output logic [1:0]              direction,
    output logic [14:0]             throttle,
    output logic signed [15:0]      control_value,
    output logic                    tilt_exceeded
);

    localparam int PTR_W = (RING_LENGTH > 1) ? $clog2(RING_LENGTH) : 1;
    localparam int TOT_W = SAMPLE_W + $clog2(RING_LENGTH);
    localparam int ND_W  = 41;
    localparam int SUM_W = DIV_W + 2;

    logic signed [15:0] off_reg;
    logic [15:0]        kp_reg;
    logic [15:0]        ki_reg;
    logic [15:0]        kd_reg;
    logic [15:0]        dt_reg;
    logic signed [31:0] imax_reg;
    logic signed [31:0] imin_reg;

    logic [15:0]              ring_mem [RING_LENGTH];
    logic [RING_LENGTH-1:0]   vld_reg;
    logic [PTR_W-1:0]         ptr_reg;
    logic signed [TOT_W-1:0]  tot_reg;
    logic signed [TOT_W-1:0]  tot_next;
    logic signed [31:0]       integ_reg;
    logic signed [31:0]       integ_next;
    logic signed [16:0]       prev_reg;

    logic signed [15:0]       a_reg;
    logic signed [15:0]       a_next;
    logic signed [15:0]       old_reg;
    logic                     old_vld_reg;
    logic signed [15:0]       avg_reg;
    logic signed [15:0]       avg_next;
    logic signed [16:0]       err_reg;
    logic signed [16:0]       err_next;
    logic signed [9:0]        dlt_reg;
    logic signed [9:0]        dlt_next;
    logic                     big_reg;
    logic [31:0]              p1_reg;
    logic [19:0]              ki10_reg;
    logic [19:0]              ki10_next;
    logic [31:0]              kddt_reg;
    logic [DIV_W-1:0]         ni_reg;
    logic [ND_W-1:0]          nd_reg;
    logic signed [DIV_W:0]    itm_reg;
    logic signed [DIV_W:0]    itm_next;
    logic signed [19:0]       dtm_reg;
    logic signed [19:0]       dtm_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic                     neg_reg;
    logic [31:0]              mag_reg;
    logic [31:0]              mag_next;
    logic [47:0]              cp_reg;
    logic signed [15:0]       cn_reg;
    logic signed [15:0]       cn_next;
    dir_t                     dir_reg;
    dir_t                     dir_next;
    logic [14:0]              thr_reg;
    logic [14:0]              thr_next;
    logic signed [15:0]       cv_reg;
    logic                     exc_reg;

    logic [TOT_W-1:0]   tot_mag;
    logic [31:0]        s_mag;
    logic [9:0]         dlt_abs;
    logic [47:0]        sdt_prod;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIVR_W-1:0]  div_divisor;
    logic [DIV_W-1:0]   quotient;
    logic               div_done;

    tpmd_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    assign status.div_done = div_done;

    assign tot_mag  = tot_reg[TOT_W-1] ? (~tot_reg + 1'b1) : tot_reg;
    assign s_mag    = integ_reg[31] ? (~integ_reg + 32'd1) : integ_reg;
    assign dlt_abs  = dlt_reg[9] ? (~dlt_reg + 10'd1) : dlt_reg;
    assign sdt_prod = s_mag * dt_reg;
    assign ki10_next = ({4'b0, ki_reg} << 3) + ({4'b0, ki_reg} << 1);

    always_comb
    begin
        div_dividend = '0;
        div_divisor  = '0;
        unique case (cmd.div_sel)
            DSEL_AVG:
            begin
                div_dividend = DIV_W'(tot_mag);
                div_divisor  = DIVR_W'(RING_LENGTH);
            end
            DSEL_I:
            begin
                div_dividend = ni_reg;
                div_divisor  = kp_reg;
            end
            DSEL_D:
            begin
                div_dividend = DIV_W'(nd_reg[ND_W-1:16]);
                div_divisor  = kp_reg;
            end
            DSEL_C:
            begin
                div_dividend = DIV_W'(cp_reg);
                div_divisor  = C_SCALE;
            end
        endcase
    end

    always_comb
    begin
        logic signed [16:0] a_diff;
        logic signed [15:0] old_val;
        logic signed [32:0] s_sum;
        logic signed [32:0] imax_x;
        logic signed [32:0] imin_x;
        logic signed [17:0] dlt_w;
        logic [16:0]        avg_abs;
        logic [16:0]        avg_v;
        logic [DIV_W:0]     q_ext;
        logic [18:0]        dtm_abs;
        logic [19:0]        dtm_ext;
        logic [SUM_W-1:0]   sum_abs;
        logic [16:0]        cn_neg;
        logic signed [16:0] cn_x;
        logic [16:0]        cv_abs;

        a_diff = tilt_sample - off_reg;
        if (a_diff > SAT_HI)
        begin
            a_diff = SAT_HI;
        end
        else if (a_diff < SAT_LO)
        begin
            a_diff = SAT_LO;
        end
        a_next = a_diff[15:0];

        old_val  = old_vld_reg ? old_reg : 16'sd0;
        tot_next = tot_reg + a_reg - old_val;

        avg_abs  = quotient[16:0];
        avg_v    = tot_reg[TOT_W-1] ? (~avg_abs + 17'd1) : avg_abs;
        avg_next = avg_v[15:0];

        err_next = avg_reg - off_reg;
        s_sum    = integ_reg + err_next;
        imax_x   = imax_reg;
        imin_x   = imin_reg;
        if (s_sum > imax_x)
        begin
            integ_next = imax_reg;
        end
        else if (s_sum < imin_x)
        begin
            integ_next = imin_reg;
        end
        else
        begin
            integ_next = s_sum[31:0];
        end

        dlt_w = err_next - prev_reg;
        if (dlt_w > DLT_HI)
        begin
            dlt_w = DLT_HI;
        end
        else if (dlt_w < DLT_LO)
        begin
            dlt_w = DLT_LO;
        end
        dlt_next = dlt_w[9:0];

        q_ext    = {1'b0, quotient};
        itm_next = integ_reg[31] ? (~q_ext + 1'b1) : q_ext;

        dtm_abs  = (quotient > DIV_W'(DTM_LIMIT)) ? DTM_LIMIT : quotient[18:0];
        dtm_ext  = {1'b0, dtm_abs};
        dtm_next = dlt_reg[9] ? (~dtm_ext + 20'd1) : dtm_ext;

        sum_next = err_reg + itm_reg + dtm_reg;
        sum_abs  = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        mag_next = (sum_abs > SUM_W'(MAG_CLIP)) ? MAG_CLIP : sum_abs[31:0];

        cn_neg = ~quotient[16:0] + 17'd1;
        if (kp_reg == '0)
        begin
            cn_next = 16'sd0;
        end
        else if (!neg_reg)
        begin
            cn_next = (quotient > DIV_W'(CN_MAX)) ? CN_MAX : quotient[15:0];
        end
        else
        begin
            cn_next = (quotient > DIV_W'(CN_NEG_MAG)) ? CN_MIN : cn_neg[15:0];
        end

        cn_x   = cn_reg;
        cv_abs = cn_x[16] ? (~cn_x + 17'd1) : cn_x;
        if (big_reg)
        begin
            dir_next = DIR_STOP;
            thr_next = '0;
        end
        else
        begin
            if (cn_reg > 16'sd0)
            begin
                dir_next = DIR_FWD;
            end
            else if (cn_reg[15])
            begin
                dir_next = DIR_BACK;
            end
            else
            begin
                dir_next = DIR_STOP;
            end
            thr_next = (cv_abs > 17'd32767) ? THROTTLE_MAX : cv_abs[14:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            old_reg <= ring_mem[ptr_reg];
        end
        if (cmd.ring_update)
        begin
            ring_mem[ptr_reg] <= a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= '0;
            kp_reg    <= RST_GAIN_P;
            ki_reg    <= '0;
            kd_reg    <= '0;
            dt_reg    <= RST_SAMPLE_PERIOD;
            imax_reg  <= RST_INTEGRAL_MAX;
            imin_reg  <= RST_INTEGRAL_MIN;
            vld_reg   <= '0;
            ptr_reg   <= '0;
            tot_reg   <= '0;
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_ANGLE_OFFSET:  off_reg  <= cfg_data[15:0];
                    CFG_GAIN_P:        kp_reg   <= cfg_data[15:0];
                    CFG_GAIN_I:        ki_reg   <= cfg_data[15:0];
                    CFG_GAIN_D:        kd_reg   <= cfg_data[15:0];
                    CFG_SAMPLE_PERIOD: dt_reg   <= cfg_data[15:0];
                    CFG_INTEGRAL_MAX:  imax_reg <= cfg_data;
                    CFG_INTEGRAL_MIN:  imin_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.ring_update)
            begin
                vld_reg[ptr_reg] <= 1'b1;
                tot_reg          <= tot_next;
                if (ptr_reg == PTR_W'(RING_LENGTH - 1))
                begin
                    ptr_reg <= '0;
                end
                else
                begin
                    ptr_reg <= ptr_reg + PTR_W'(1);
                end
            end
            if (cmd.err_update)
            begin
                integ_reg <= integ_next;
                prev_reg  <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            a_reg       <= a_next;
            old_vld_reg <= vld_reg[ptr_reg];
        end
        if (cmd.div_capture)
        begin
            unique case (cmd.div_sel)
                DSEL_AVG: avg_reg <= avg_next;
                DSEL_I:   itm_reg <= itm_next;
                DSEL_D:   dtm_reg <= dtm_next;
                DSEL_C:   cn_reg  <= cn_next;
            endcase
        end
        if (cmd.err_update)
        begin
            err_reg <= err_next;
            dlt_reg <= dlt_next;
            big_reg <= (avg_reg > TILT_LIMIT) || (avg_reg < -TILT_LIMIT);
        end
        if (cmd.mul_sdt)
        begin
            p1_reg   <= sdt_prod[47:16];
            ki10_reg <= ki10_next;
        end
        if (cmd.mul_kddt)
        begin
            kddt_reg <= kd_reg * dt_reg;
        end
        if (cmd.mul_ni)
        begin
            ni_reg <= p1_reg * ki10_reg;
        end
        if (cmd.mul_nd)
        begin
            nd_reg <= dlt_abs[8:0] * kddt_reg;
        end
        if (cmd.sum_update)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.clip_update)
        begin
            neg_reg <= sum_reg[SUM_W-1];
            mag_reg <= mag_next;
        end
        if (cmd.mul_cp)
        begin
            cp_reg <= mag_reg * kp_reg;
        end
        if (cmd.result_load)
        begin
            dir_reg <= dir_next;
            thr_reg <= thr_next;
            cv_reg  <= cn_reg;
            exc_reg <= big_reg;
        end
    end

    assign direction     = dir_reg;
    assign throttle      = thr_reg;
    assign control_value = cv_reg;
    assign tilt_exceeded = exc_reg;

endmodule

// ----- design/tpmd_ctrl.sv -----
// Controller state machine that sequences one sample through the datapath.
module tpmd_ctrl
    import tpmd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = DSEL_AVG;
        state_next  = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_RING;
                end
            end
            ST_RING:
            begin
                cmd.ring_update = 1'b1;
                state_next      = ST_AVG_GO;
            end
            ST_AVG_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    state_next      = ST_ERR;
                end
            end
            ST_ERR:
            begin
                cmd.err_update = 1'b1;
                state_next     = ST_MUL_SDT;
            end
            ST_MUL_SDT:
            begin
                cmd.mul_sdt = 1'b1;
                state_next  = ST_MUL_KDDT;
            end
            ST_MUL_KDDT:
            begin
                cmd.mul_kddt = 1'b1;
                state_next   = ST_MUL_NI;
            end
            ST_MUL_NI:
            begin
                cmd.mul_ni = 1'b1;
                state_next = ST_MUL_ND;
            end
            ST_MUL_ND:
            begin
                cmd.mul_nd = 1'b1;
                state_next = ST_I_GO;
            end
            ST_I_GO:
            begin
                cmd.div_sel   = DSEL_I;
                cmd.div_start = 1'b1;
                state_next    = ST_I_WAIT;
            end
            ST_I_WAIT:
            begin
                cmd.div_sel = DSEL_I;
                if (status.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    state_next      = ST_D_GO;
                end
            end
            ST_D_GO:
            begin
                cmd.div_sel   = DSEL_D;
                cmd.div_start = 1'b1;
                state_next    = ST_D_WAIT;
            end
            ST_D_WAIT:
            begin
                cmd.div_sel = DSEL_D;
                if (status.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    state_next      = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_update = 1'b1;
                state_next     = ST_CLIP;
            end
            ST_CLIP:
            begin
                cmd.clip_update = 1'b1;
                state_next      = ST_MUL_CP;
            end
            ST_MUL_CP:
            begin
                cmd.mul_cp = 1'b1;
                state_next = ST_C_GO;
            end
            ST_C_GO:
            begin
                cmd.div_sel   = DSEL_C;
                cmd.div_start = 1'b1;
                state_next    = ST_C_WAIT;
            end
            ST_C_WAIT:
            begin
                cmd.div_sel = DSEL_C;
                if (status.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    state_next      = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- design/tpmd_checker.sv -----
// Port-level assertions for the tilt PID motor drive and their binding to the top level.
module tpmd_checker
    import tpmd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_write,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic signed [15:0]    tilt_sample,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [1:0]            direction,
    input logic [14:0]           throttle,
    input logic signed [15:0]    control_value,
    input logic                  tilt_exceeded
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input beat accepted while a previous beat is still in work.");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(control_value)
            && $stable(direction) && $stable(throttle) && $stable(tilt_exceeded))
        else $error("Output beat changed or dropped before it was taken.");

    a_tilt_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tilt_exceeded |-> direction == DIR_STOP && throttle == 15'd0)
        else $error("Excess tilt did not stop the motor.");

    a_dir_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tilt_exceeded |-> (direction == DIR_BACK) == control_value[15])
        else $error("Direction does not match the sign of the control value.");

    a_zero_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && control_value == 16'sd0 |-> direction == DIR_STOP && throttle == 15'd0)
        else $error("Zero control value did not give stop.");

endmodule

bind tilt_pid_motor_drive tpmd_checker u_tpmd_checker (.*);

// ----- tb/tb_tilt_pid_motor_drive.sv -----
// Self-checking testbench for the tilt PID motor drive: directed table, then random phases.
module tb_tilt_pid_motor_drive;
    timeunit 1ns;
    timeprecision 1ps;

    import tpmd_pkg::*;

    localparam int     CLK_HALF        = 10;
    localparam int     RING_LEN        = 8;
    localparam int     N_PHASES        = 12;
    localparam int     ITEMS_PER_PHASE = 161;
    localparam int     SETTLE_CYCLES   = 200;
    localparam int     MAX_REPORTS     = 200;
    localparam longint TILT_STOP       = 2867;
    localparam longint DELTA_CLAMP     = 410;
    localparam longint DTERM_CLAMP     = 491520;
    localparam longint SUM_CLAMP       = 64'sd1099511627776;
    localparam longint CN_DIV          = 40960;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        dir_t               dir;
        logic [14:0]        thr;
        logic signed [15:0] cv;
        logic               over;
    } drive_result_t;

    typedef enum logic {
        ROW_CFG,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [31:0]           data;
        logic                  typed;
        drive_result_t         want;
    } stim_row_t;

    localparam drive_result_t NO_CHECK = '0;
    localparam int N_ROWS = 47;

    stim_row_t directed_rows [N_ROWS] = '{
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_0000, 1'b1, '{DIR_STOP, 15'h0000, 16'sh0000, 1'b0}},
        '{ROW_CFG,    CFG_GAIN_P,        32'h0000_FFFF, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_GAIN_I,        32'h0000_FFFF, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_SAMPLE_PERIOD, 32'h0000_FFFF, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_INTEGRAL_MAX,  32'h8000_0000, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_INTEGRAL_MIN,  32'h8000_0000, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_0000, 1'b1, '{DIR_BACK, 15'h7FFF, 16'sh8000, 1'b0}},
        '{ROW_CFG,    CFG_INTEGRAL_MAX,  32'h7FFF_FFFF, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_INTEGRAL_MIN,  32'h7FFF_FFFF, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_GAIN_P,        32'h0000_0001, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_0000, 1'b1, '{DIR_FWD, 15'h7FFF, 16'sh7FFF, 1'b0}},
        '{ROW_CFG,    CFG_INTEGRAL_MAX,  32'h0000_A000, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_INTEGRAL_MIN,  32'hFFFF_6000, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_GAIN_P,        32'h0000_0100, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_GAIN_I,        32'h0000_0100, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_GAIN_D,        32'h0000_FFFF, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_SAMPLE_PERIOD, 32'h0000_028F, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_7FFF, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_8000, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_8000, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_0000, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_0400, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_ANGLE_OFFSET,  32'h0000_8000, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_7FFF, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_0001, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_ANGLE_OFFSET,  32'h0000_7FFF, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_8000, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_FFFF, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_GAIN_P,        32'h0000_0000, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_5555, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_AAAA, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_UNUSED,        32'hFFFF_FFFF, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_ANGLE_OFFSET,  32'h0000_0000, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_GAIN_P,        32'h0000_0100, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_0000, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_0B33, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_F4CD, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_INTEGRAL_MAX,  32'hFFFF_FF9C, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_INTEGRAL_MIN,  32'h0000_0064, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_0100, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_FF00, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_INTEGRAL_MAX,  32'h0000_A000, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_INTEGRAL_MIN,  32'hFFFF_6000, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_GAIN_D,        32'h0000_0000, 1'b0, NO_CHECK},
        '{ROW_CFG,    CFG_SAMPLE_PERIOD, 32'h0000_0001, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_0C00, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, CFG_UNUSED,        32'h0000_0000, 1'b0, NO_CHECK}
    };

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic signed [15:0]    tilt_sample = '0;
    logic                  out_ready   = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic [1:0]            direction;
    logic [14:0]           throttle;
    logic signed [15:0]    control_value;
    logic                  tilt_exceeded;

    longint angle_hist [RING_LEN] = '{default: 0};
    int     hist_ptr  = 0;
    longint hist_sum  = 0;
    longint err_accum = 0;
    longint last_err  = 0;

    longint ofs_q  = 0;
    longint kp_q   = 256;
    longint ki_q   = 0;
    longint kd_q   = 0;
    longint dt_q   = 655;
    longint imax_q = 40960;
    longint imin_q = -40960;

    drive_result_t drive_expected [$];
    int            mismatch_count = 0;
    int            in_idle_pct    = 13;
    int            out_idle_pct   = 51;

    tilt_pid_motor_drive dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .tilt_sample   (tilt_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .direction     (direction),
        .throttle      (throttle),
        .control_value (control_value),
        .tilt_exceeded (tilt_exceeded)
    );

    always #CLK_HALF clk = ~clk;

    function automatic longint clamp64(input longint x, input longint lo, input longint hi);
        if (x > hi)
        begin
            return hi;
        end
        if (x < lo)
        begin
            return lo;
        end
        return x;
    endfunction

    // Advances the controller state by one tilt sample and returns the motor command.
    function automatic drive_result_t drive_law_step(input logic signed [15:0] tilt);
        longint        a;
        longint        avg;
        longint        err;
        longint        s;
        longint        itm;
        longint        dlt;
        longint        dtm;
        longint        sum;
        longint        cn;
        longint        mag;
        logic          big;
        drive_result_t r;
        a = clamp64(longint'(tilt) - ofs_q, -32768, 32767);
        hist_sum = hist_sum + a - angle_hist[hist_ptr];
        angle_hist[hist_ptr] = a;
        hist_ptr = (hist_ptr + 1) % RING_LEN;
        avg = hist_sum / RING_LEN;
        err = avg - ofs_q;
        s = err_accum + err;
        if (s > imax_q)
        begin
            s = imax_q;
        end
        else if (s < imin_q)
        begin
            s = imin_q;
        end
        err_accum = s;
        dlt = clamp64(err - last_err, -DELTA_CLAMP, DELTA_CLAMP);
        last_err = err;
        if (kp_q == 0)
        begin
            cn = 0;
        end
        else
        begin
            itm = ((s * dt_q) / 65536) * ki_q * 10 / kp_q;
            dtm = clamp64((dlt * kd_q * dt_q) / (kp_q * 65536), -DTERM_CLAMP, DTERM_CLAMP);
            sum = clamp64(err + itm + dtm, -SUM_CLAMP, SUM_CLAMP);
            cn = clamp64((sum * kp_q) / CN_DIV, -32768, 32767);
        end
        if (cn > 0)
        begin
            r.dir = DIR_FWD;
        end
        else if (cn < 0)
        begin
            r.dir = DIR_BACK;
        end
        else
        begin
            r.dir = DIR_STOP;
        end
        mag = (cn < 0) ? -cn : cn;
        if (mag > 32767)
        begin
            mag = 32767;
        end
        big = (avg > TILT_STOP) || (avg < -TILT_STOP);
        if (big)
        begin
            r.dir = DIR_STOP;
            mag = 0;
        end
        r.thr = 15'(mag);
        r.cv = 16'(cn);
        r.over = big;
        return r;
    endfunction

    function automatic logic [31:0] pick_register_value(input logic [CFG_IDX_W-1:0] idx);
        logic [31:0] v;
        int          roll;
        v = $urandom;
        roll = $urandom_range(9);
        case (idx)
            CFG_ANGLE_OFFSET:
            begin
                if (roll == 0) v[15:0] = 16'h8000;
                else if (roll == 1) v[15:0] = 16'h7FFF;
                else if (roll > 3) v[15:0] = 16'($urandom_range(8000)) - 16'd4000;
            end
            CFG_GAIN_P:
            begin
                if (roll == 0) v[15:0] = 16'h0000;
                else if (roll == 1) v[15:0] = 16'h0001;
                else if (roll == 2) v[15:0] = 16'hFFFF;
                else if (roll > 4) v[15:0] = 16'($urandom_range(1024, 64));
            end
            CFG_GAIN_I, CFG_GAIN_D:
            begin
                if (roll == 0) v[15:0] = 16'h0000;
                else if (roll == 1) v[15:0] = 16'hFFFF;
                else if (roll > 3) v[15:0] = 16'($urandom_range(1024));
            end
            CFG_SAMPLE_PERIOD:
            begin
                if (roll == 0) v[15:0] = 16'h0001;
                else if (roll == 1) v[15:0] = 16'hFFFF;
                else if (roll > 3) v[15:0] = 16'($urandom_range(2000, 100));
            end
            CFG_INTEGRAL_MAX:
            begin
                if (roll == 0) v = 32'h7FFF_FFFF;
                else if (roll == 1) v = 32'h8000_0000;
                else if (roll > 2) v = $urandom_range(300000, 1000);
            end
            CFG_INTEGRAL_MIN:
            begin
                if (roll == 0) v = 32'h8000_0000;
                else if (roll == 1) v = 32'h7FFF_FFFF;
                else if (roll > 2) v = 32'(-int'($urandom_range(300000, 1000)));
            end
            default:
            begin
            end
        endcase
        return v;
    endfunction

    // Waits for the block to go idle, then writes one register and mirrors it.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        in_valid <= 1'b0;
        while (drive_expected.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_ANGLE_OFFSET:  ofs_q  = longint'($signed(data[15:0]));
            CFG_GAIN_P:        kp_q   = longint'(data[15:0]);
            CFG_GAIN_I:        ki_q   = longint'(data[15:0]);
            CFG_GAIN_D:        kd_q   = longint'(data[15:0]);
            CFG_SAMPLE_PERIOD: dt_q   = longint'(data[15:0]);
            CFG_INTEGRAL_MAX:  imax_q = longint'($signed(data));
            CFG_INTEGRAL_MIN:  imin_q = longint'($signed(data));
            default:
            begin
            end
        endcase
    endtask

    task automatic send_tilt(input logic signed [15:0] v, input logic use_typed,
                             input drive_result_t typed_want);
        drive_result_t r;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        tilt_sample <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = drive_law_step(v);
        drive_expected.push_back(use_typed ? typed_want : r);
    endtask

    function automatic void check_field(input string what, input longint want, input longint got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
            begin
                $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge clk)
    begin
        drive_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (drive_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: beat with nothing expected, expected none got %0d/%0d/%0d/%0b",
                             $time, direction, throttle, control_value, tilt_exceeded);
                end
            end
            else
            begin
                want = drive_expected.pop_front();
                check_field("direction", want.dir, direction);
                check_field("throttle", want.thr, throttle);
                check_field("control_value", $signed(want.cv), control_value);
                check_field("tilt_exceeded", want.over, tilt_exceeded);
            end
        end
    end

    initial
    begin
        #30ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int                 walk;
        int                 pick;
        logic signed [15:0] smp;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                write_register(directed_rows[i].idx, directed_rows[i].data);
            end
            else
            begin
                send_tilt(directed_rows[i].data[15:0], directed_rows[i].typed,
                          directed_rows[i].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph == N_PHASES / 3)
            begin
                in_idle_pct  = 51;
                out_idle_pct = 13;
            end
            else if (ph == 2 * N_PHASES / 3)
            begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            for (int r = 0; r <= int'(CFG_INTEGRAL_MIN); r++)
            begin
                write_register(CFG_IDX_W'(r), pick_register_value(CFG_IDX_W'(r)));
            end
            walk = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Mostly a slowly drifting tilt around the upright point, plus noise and extremes.
                pick = $urandom_range(99);
                if (pick < 60)
                begin
                    walk = int'(clamp64(walk + int'($urandom_range(400)) - 200, -3500, 3500));
                    smp = 16'(clamp64(ofs_q + walk, -32768, 32767));
                end
                else if (pick < 85)
                begin
                    smp = 16'($urandom);
                end
                else
                begin
                    smp = pick[0] ? 16'sh7FFF : 16'sh8000;
                end
                if ($urandom_range(199) == 0)
                begin
                    in_valid <= 1'b0;
                    while (drive_expected.size() != 0) @(posedge clk);
                end
                send_tilt(smp, 1'b0, NO_CHECK);
            end
        end

        in_valid <= 1'b0;
        while (drive_expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/tpmd_pkg.sv
design/tpmd_divider.sv
design/tpmd_datapath.sv
design/tpmd_ctrl.sv
design/tilt_pid_motor_drive.sv
design/tpmd_checker.sv
tb/tb_tilt_pid_motor_drive.sv
